/* design/wsd_pkg.sv */
`default_nettype none

package wsd_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_EXT    = 3'd2;
  localparam logic [2:0] PH_KEY    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  // Fragment kinds of the current frame.
  localparam logic [1:0] FK_SINGLE = 2'd0;
  localparam logic [1:0] FK_FIRST  = 2'd1;
  localparam logic [1:0] FK_MIDDLE = 2'd2;
  localparam logic [1:0] FK_LAST   = 2'd3;

  // Error kinds.
  localparam logic ERR_RSV    = 1'b0;
  localparam logic ERR_OPCODE = 1'b1;

  // Header byte fields and length escape codes.
  localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
  localparam logic [7:0] HDR_RSV_BITS = 8'h70;
  localparam logic [6:0] LEN_EXT16    = 7'h7e;
  localparam logic [6:0] LEN_EXT64    = 7'h7f;

  // Extended length and mask key byte counts.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result beat.
  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [3:0] message_opcode;
    logic       frame_done;
    logic       message_done;
    logic       error;
    logic       error_kind;
  } res_t;

  // True for opcodes 3 to 7 and 11 to 15.
  function automatic logic opcode_reserved(input logic [3:0] op);
    return ((op >= 4'd3) && (op <= 4'd7)) || (op >= 4'd11);
  endfunction

endpackage

`default_nettype wire

/* design/wsd_core.sv */
`default_nettype none

module wsd_core #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire logic [7:0]    in_byte,
  output wsd_pkg::res_t      res
);
  import wsd_pkg::*;

  logic [2:0]             parse_phase, parse_phase_next;
  logic [1:0]             fragment_kind, fragment_kind_next;
  logic [3:0]             fragment_opcode, fragment_opcode_next;
  logic [3:0]             frame_opcode, frame_opcode_next;
  logic                   mask_enabled, mask_enabled_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [3:0]             header_bytes_left, header_bytes_left_next;
  logic [LENGTH_BITS-1:0] payload_length, payload_length_next;
  logic [LENGTH_BITS-1:0] payload_count, payload_count_next;

  logic [6:0]             len7;
  logic [3:0]             op;
  logic [7:0]             key_byte;
  logic                   done;
  logic                   err;
  logic                   err_kind;
  logic                   data_valid;
  logic [7:0]             data_byte;

  assign len7 = in_byte[6:0];
  assign op   = in_byte[3:0];

  // Key byte for this payload position; the first key byte sits in the top bits.
  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Next state and result for one stream byte.
  always_comb begin
    parse_phase_next       = parse_phase;
    fragment_kind_next     = fragment_kind;
    fragment_opcode_next   = fragment_opcode;
    frame_opcode_next      = frame_opcode;
    mask_enabled_next      = mask_enabled;
    mask_key_next          = mask_key;
    header_bytes_left_next = header_bytes_left;
    payload_length_next    = payload_length;
    payload_count_next     = payload_count;
    done                   = 1'b0;
    err                    = 1'b0;
    err_kind               = ERR_RSV;
    data_valid             = 1'b0;
    data_byte              = 8'd0;

    case (parse_phase)
      PH_LEN: begin
        mask_enabled_next   = in_byte[7];
        mask_key_next       = 32'd0;
        payload_length_next = '0;
        if (len7 == LEN_EXT16) begin
          header_bytes_left_next = EXT16_BYTES;
          parse_phase_next       = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          header_bytes_left_next = EXT64_BYTES;
          parse_phase_next       = PH_EXT;
        end else begin
          payload_length_next = {{(LENGTH_BITS-7){1'b0}}, len7};
          if (in_byte[7]) begin
            header_bytes_left_next = KEY_BYTES;
            parse_phase_next       = PH_KEY;
          end else begin
            payload_count_next = '0;
            if (len7 == 7'd0) begin
              parse_phase_next = PH_HEADER;
              done             = 1'b1;
            end else begin
              parse_phase_next = PH_DATA;
            end
          end
        end
      end

      PH_EXT: begin
        // Shift in big-endian length bytes, saturating once the top byte is used.
        if (payload_length[LENGTH_BITS-1 -: 8] != 8'd0) begin
          payload_length_next = '1;
        end else begin
          payload_length_next = {payload_length[LENGTH_BITS-9:0], in_byte};
        end
        header_bytes_left_next = header_bytes_left - 4'd1;
        if (header_bytes_left_next == 4'd0) begin
          if (mask_enabled) begin
            header_bytes_left_next = KEY_BYTES;
            parse_phase_next       = PH_KEY;
          end else begin
            payload_count_next = '0;
            if (payload_length_next == '0) begin
              parse_phase_next = PH_HEADER;
              done             = 1'b1;
            end else begin
              parse_phase_next = PH_DATA;
            end
          end
        end
      end

      PH_KEY: begin
        mask_key_next          = {mask_key[23:0], in_byte};
        header_bytes_left_next = header_bytes_left - 4'd1;
        if (header_bytes_left_next == 4'd0) begin
          payload_count_next = '0;
          if (payload_length == '0) begin
            parse_phase_next = PH_HEADER;
            done             = 1'b1;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
      end

      PH_DATA: begin
        data_valid         = 1'b1;
        data_byte          = mask_enabled ? (in_byte ^ key_byte) : in_byte;
        payload_count_next = payload_count + 1'b1;
        if (payload_count_next >= payload_length) begin
          done             = 1'b1;
          parse_phase_next = PH_HEADER;
        end
      end

      default: begin
        // Header byte: reserved bits are checked before the opcode.
        if ((in_byte & HDR_RSV_BITS) != 8'd0) begin
          err      = 1'b1;
          err_kind = ERR_RSV;
        end else if (opcode_reserved(op)) begin
          err      = 1'b1;
          err_kind = ERR_OPCODE;
        end else begin
          if ((in_byte & HDR_FIN_BIT) == 8'd0) begin
            fragment_kind_next = (op != 4'd0) ? FK_FIRST : FK_MIDDLE;
          end else begin
            fragment_kind_next = (op == 4'd0) ? FK_LAST : FK_SINGLE;
          end
          if (fragment_kind_next == FK_FIRST) begin
            fragment_opcode_next = op;
          end
          frame_opcode_next      = op;
          mask_enabled_next      = 1'b0;
          header_bytes_left_next = 4'd0;
          payload_length_next    = '0;
          payload_count_next     = '0;
          parse_phase_next       = PH_LEN;
        end
        if (err) begin
          parse_phase_next = PH_HEADER;
        end
      end
    endcase
  end

  // Result fields, taken from the state after this byte.
  always_comb begin
    res.data_valid     = data_valid;
    res.data_byte      = data_byte;
    res.message_opcode = (frame_opcode_next != 4'd0) ? frame_opcode_next
                                                     : fragment_opcode_next;
    res.frame_done     = done;
    res.message_done   = done && ((fragment_kind_next == FK_SINGLE) ||
                                  (fragment_kind_next == FK_LAST));
    res.error          = err;
    res.error_kind     = err_kind;
  end

  // Parser state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_HEADER;
      fragment_kind     <= FK_SINGLE;
      fragment_opcode   <= 4'd0;
      frame_opcode      <= 4'd0;
      mask_enabled      <= 1'b0;
      mask_key          <= 32'd0;
      header_bytes_left <= 4'd0;
      payload_length    <= '0;
      payload_count     <= '0;
    end else if (step) begin
      parse_phase       <= parse_phase_next;
      fragment_kind     <= fragment_kind_next;
      fragment_opcode   <= fragment_opcode_next;
      frame_opcode      <= frame_opcode_next;
      mask_enabled      <= mask_enabled_next;
      mask_key          <= mask_key_next;
      header_bytes_left <= header_bytes_left_next;
      payload_length    <= payload_length_next;
      payload_count     <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

/* design/websocket_frame_deframer_top.sv */
// An accepted byte passes through the input register, then the result register, which presents its result.
// Throughput: one byte per cycle, sustained, whenever the result side drains.
// The input register holds one byte while a result waits, so input and output stall apart.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to waiting for a header byte with all frame state cleared.
`default_nettype none

module websocket_frame_deframer_top #(
  parameter int LENGTH_BITS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            data_valid,
  output logic [7:0]      data_byte,
  output logic [3:0]      message_opcode,
  output logic            frame_done,
  output logic            message_done,
  output logic            error,
  output logic            error_kind
);
  import wsd_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       step;
  res_t       res;
  res_t       out_res;

  // A held byte is parsed when the result register is free or draining.
  assign step     = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= in_byte;
    end
  end

  wsd_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .in_byte (hold_byte),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign data_valid     = out_res.data_valid;
  assign data_byte      = out_res.data_byte;
  assign message_opcode = out_res.message_opcode;
  assign frame_done     = out_res.frame_done;
  assign message_done   = out_res.message_done;
  assign error          = out_res.error;
  assign error_kind     = out_res.error_kind;

endmodule

`default_nettype wire

/* design/wsd_checker.sv */
`default_nettype none

module wsd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       data_valid,
  input wire logic [7:0] data_byte,
  input wire logic       frame_done,
  input wire logic       message_done,
  input wire logic       error,
  input wire logic       error_kind
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(frame_done))
    else $error("result beat changed while stalled");

  // Non-payload beats carry a zero data byte.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data_byte == 8'd0)
    else $error("data byte nonzero on a non-payload beat");

  // A message can only end where a frame ends.
  a_msg_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> frame_done)
    else $error("message done without frame done");

  // A rejected header byte is neither payload nor a frame end.
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !data_valid && !frame_done)
    else $error("error beat also flagged payload or frame end");

  // The error kind is only set on an error beat.
  a_kind_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind |-> error)
    else $error("error kind set without error");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data_valid   (data_valid),
  .data_byte    (data_byte),
  .frame_done   (frame_done),
  .message_done (message_done),
  .error        (error),
  .error_kind   (error_kind)
);

`default_nettype wire
